// ===== hw/rtl/sba_pkg.sv =====
// Shared definitions for the sector bitmap allocator.
// Holds field widths, parameter defaults and the operation codes.
// No dependencies.
package sba_pkg;

   localparam int TRACK_W      = 8;
   localparam int SECTOR_W     = 3;
   localparam int DEF_TRACKS   = 160;
   localparam int DEF_SECTORS  = 5;

   typedef enum logic [1:0] {
      OP_LOAD        = 2'd0,
      OP_ALLOC_FIRST = 2'd1,
      OP_ALLOC_AT    = 2'd2,
      OP_RELEASE     = 2'd3
   } op_type;

endpackage

// ===== hw/rtl/sba_cell.sv =====
// One cell of the rotating track ring: holds the allocation bits of one track.
// Loads its neighbor's bits when the ring shifts. Depends on sba_pkg.
module sba_cell
   import sba_pkg::*;
#(
   parameter int WIDTH = DEF_SECTORS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] bits_ff;
   logic [WIDTH-1:0] bits_in;

   assign bits_in  = shift_en ? data_in : bits_ff;
   assign data_out = bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
   end

endmodule

// ===== hw/rtl/sector_bitmap_allocator.sv =====
// Sector bitmap allocator: a ring of track cells that rotates one track per cycle while it seeks or scans.
// Disk full and out-of-range tracks are answered straight from idle; otherwise the ring turns until the target
// track is at the head; allocate-first stops there at track zero, then scans to the first track with a free sector.
// One operation at a time; busy drops in the cycle the result beat is on the ports,
// so the next beat can be taken at the edge that ends it.
// The result beat is a one-cycle strobe that the receiver cannot stall.
// Synchronous reset clears every cell (all sectors free) and sets the count to the total.
module sector_bitmap_allocator
   import sba_pkg::*;
#(
   parameter int TRACKS  = DEF_TRACKS,
   parameter int SECTORS = DEF_SECTORS,
   localparam int COUNT_W = $clog2(TRACKS * SECTORS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_opcode,
   input  logic [TRACK_W-1:0]  req_track,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic [SECTORS-1:0]  req_load_bits,
   output logic                rsp_valid,
   output logic                rsp_status,
   output logic [TRACK_W-1:0]  rsp_out_track,
   output logic [SECTOR_W-1:0] rsp_out_sector,
   output logic [SECTORS-1:0]  rsp_track_bits,
   output logic [COUNT_W-1:0]  rsp_free_count
);

   localparam int HEAD_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int POP_W  = $clog2(SECTORS + 1);
   localparam int TOTAL  = TRACKS * SECTORS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEEK,
      ST_SCAN
   } state_type;

   state_type             state_ff;
   logic [HEAD_W-1:0]     head_ff;
   logic [COUNT_W-1:0]    free_ff;
   op_type                op_ff;
   logic [TRACK_W-1:0]    tgt_ff;
   logic [SECTOR_W-1:0]   sec_ff;
   logic [SECTORS-1:0]    bits_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_status_ff;
   logic [TRACK_W-1:0]    rsp_track_ff;
   logic [SECTOR_W-1:0]   rsp_sector_ff;
   logic [SECTORS-1:0]    rsp_bits_ff;
   logic [COUNT_W-1:0]    rsp_free_ff;

   logic [SECTORS-1:0]    cell_q [TRACKS];
   logic [SECTORS-1:0]    head_bits;
   logic [SECTORS-1:0]    tail_bits;
   logic                  shift_en;

   logic [POP_W-1:0]      pop_old;
   logic [POP_W-1:0]      pop_new;
   logic [SECTOR_W-1:0]   first_idx;
   logic                  first_found;
   logic                  sec_ok;
   logic [SECTORS-1:0]    sec_mask;
   logic [SECTORS-1:0]    upd_bits;
   logic [COUNT_W:0]      upd_free;
   logic                  at_target;
   logic                  do_update;
   logic                  accept;
   op_type                req_op;
   logic [HEAD_W-1:0]     head_in;

   // The ring: cell i holds track (head + i) mod TRACKS, the tail takes the head's bits.
   for (genvar i = 0; i < TRACKS; i++) begin : g_ring
      logic [SECTORS-1:0] nbr;
      if (i == TRACKS - 1) begin : g_tail
         assign nbr = tail_bits;
      end else begin : g_mid
         assign nbr = cell_q[i+1];
      end
      sba_cell #(
         .WIDTH (SECTORS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .data_in  (nbr),
         .data_out (cell_q[i])
      );
   end

   assign head_bits = cell_q[0];
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && (state_ff == ST_IDLE);
   assign req_op    = op_type'(req_opcode);
   assign head_in   = (head_ff == HEAD_W'(TRACKS - 1)) ? '0 : head_ff + 1'b1;

   always_comb begin
      pop_old     = '0;
      pop_new     = '0;
      first_idx   = '0;
      first_found = 1'b0;
      for (int s = 0; s < SECTORS; s++) begin
         pop_old = pop_old + POP_W'(head_bits[s]);
         pop_new = pop_new + POP_W'(bits_ff[s]);
      end
      // Walk downward so the lowest free sector wins.
      for (int s = SECTORS - 1; s >= 0; s--) begin
         if (!head_bits[s]) begin
            first_idx   = SECTOR_W'(s);
            first_found = 1'b1;
         end
      end
   end

   always_comb begin
      sec_ok   = (32'(sec_ff) < SECTORS);
      sec_mask = SECTORS'(1) << sec_ff;
      upd_bits = head_bits;
      upd_free = {1'b0, free_ff};
      case (op_ff)
         OP_LOAD: begin
            upd_bits = bits_ff;
            upd_free = ({1'b0, free_ff} + (COUNT_W + 1)'(pop_old)) - (COUNT_W + 1)'(pop_new);
         end
         OP_ALLOC_FIRST: begin
            upd_bits = head_bits | (SECTORS'(1) << first_idx);
            upd_free = {1'b0, free_ff} - 1'b1;
         end
         OP_ALLOC_AT: begin
            if (sec_ok && ((head_bits & sec_mask) == '0)) begin
               upd_bits = head_bits | sec_mask;
               upd_free = {1'b0, free_ff} - 1'b1;
            end
         end
         OP_RELEASE: begin
            if (sec_ok && ((head_bits & sec_mask) != '0)) begin
               upd_bits = head_bits & ~sec_mask;
               upd_free = {1'b0, free_ff} + 1'b1;
            end
         end
         default: begin
            upd_bits = head_bits;
         end
      endcase
   end

   always_comb begin
      at_target = (state_ff == ST_SEEK) && (TRACK_W'(head_ff) == tgt_ff);
      do_update = (at_target && (op_ff != OP_ALLOC_FIRST)) ||
                  ((state_ff == ST_SCAN) && first_found);
      // Allocate-first stops the ring at track zero before the scan begins.
      shift_en  = ((state_ff == ST_SEEK) && !(at_target && (op_ff == OP_ALLOC_FIRST))) ||
                  (state_ff == ST_SCAN);
      tail_bits = do_update ? upd_bits : head_bits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         free_ff       <= COUNT_W'(TOTAL);
         rsp_valid_ff  <= 1'b0;
         op_ff         <= OP_LOAD;
         tgt_ff        <= '0;
         sec_ff        <= '0;
         bits_ff       <= '0;
         rsp_status_ff <= 1'b0;
         rsp_track_ff  <= '0;
         rsp_sector_ff <= '0;
         rsp_bits_ff   <= '0;
         rsp_free_ff   <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (shift_en) begin
            head_ff <= head_in;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff   <= req_op;
                  sec_ff  <= req_sector;
                  bits_ff <= req_load_bits;
                  if (req_op == OP_ALLOC_FIRST) begin
                     if (free_ff == '0) begin
                        rsp_valid_ff  <= 1'b1;
                        rsp_status_ff <= 1'b1;
                        rsp_track_ff  <= '0;
                        rsp_sector_ff <= '0;
                        rsp_bits_ff   <= '0;
                        rsp_free_ff   <= free_ff;
                     end else begin
                        tgt_ff   <= '0;
                        state_ff <= ST_SEEK;
                     end
                  end else if (9'(req_track) >= 9'(TRACKS)) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= 1'b0;
                     rsp_track_ff  <= req_track;
                     rsp_sector_ff <= (req_op == OP_LOAD) ? '0 : req_sector;
                     rsp_bits_ff   <= '0;
                     rsp_free_ff   <= free_ff;
                  end else begin
                     tgt_ff   <= req_track;
                     state_ff <= ST_SEEK;
                  end
               end
            end
            ST_SEEK: begin
               if (at_target && (op_ff == OP_ALLOC_FIRST)) begin
                  state_ff <= ST_SCAN;
               end else if (at_target) begin
                  free_ff       <= upd_free[COUNT_W-1:0];
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= 1'b0;
                  rsp_track_ff  <= tgt_ff;
                  rsp_sector_ff <= (op_ff == OP_LOAD) ? '0 : sec_ff;
                  rsp_bits_ff   <= upd_bits;
                  rsp_free_ff   <= upd_free[COUNT_W-1:0];
                  state_ff      <= ST_IDLE;
               end
            end
            ST_SCAN: begin
               if (first_found) begin
                  free_ff       <= upd_free[COUNT_W-1:0];
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= 1'b0;
                  rsp_track_ff  <= TRACK_W'(head_ff);
                  rsp_sector_ff <= first_idx;
                  rsp_bits_ff   <= upd_bits;
                  rsp_free_ff   <= upd_free[COUNT_W-1:0];
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_track  = rsp_track_ff;
   assign rsp_out_sector = rsp_sector_ff;
   assign rsp_track_bits = rsp_bits_ff;
   assign rsp_free_count = rsp_free_ff;

   // A result beat is only issued once the operation has left the ring.
   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat issued while busy");

   a_free_range : assert property (@(posedge clock) disable iff (reset)
      free_ff <= COUNT_W'(TOTAL))
      else $error("free count above total");

   a_full_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_free_count == '0))
      else $error("disk full reported with free sectors left");

   a_scan_free : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (free_ff != '0))
      else $error("scan running with no free sector");

endmodule
